// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the command link checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BDCL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdcl assertion failed");

// Check a property on every clock edge, reset included.
`define BDCL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdcl assertion failed");

`endif

// ===== rtl/bdcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcl_pkg
// Types and constants shared by the boost duty command link modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcl_pkg;

  localparam int FRAME_LEN  = 2;
  localparam int ADC_BITS   = 10;
  localparam int ADC_SHIFT  = ADC_BITS - 8;
  localparam int IDX_W      = 4;

  localparam int REPLY_LEN  = 3;
  localparam int PUSH_CNT_W = $clog2(REPLY_LEN + 1);
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  LOOP_DIVIDE_RST     = 8'd5;
  localparam logic [7:0]  BYTE_TIMEOUT_RST    = 8'd10;
  localparam logic [15:0] LINK_LOSS_LIMIT_RST = 16'd1000;
  localparam logic [8:0]  DUTY_MIN_RST        = 9'd32;
  localparam logic [8:0]  DUTY_MAX_RST        = 9'd256;
  localparam logic [9:0]  COMPLEMENT_BASE_RST = 10'd511;
  localparam logic [9:0]  BRIDGE_MAX          = 10'd1023;
  localparam logic [9:0]  BRIDGE_MIN          = 10'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_DIVIDE     = 3'd0,
    CFG_BYTE_TIMEOUT    = 3'd1,
    CFG_LINK_LOSS_LIMIT = 3'd2,
    CFG_DUTY_MIN        = 3'd3,
    CFG_DUTY_MAX        = 3'd4,
    CFG_COMPLEMENT_BASE = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_DUTY  = 1'b1
  } kind_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  rx_byte;
    logic [9:0]  out_voltage;
    logic [9:0]  in_voltage;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  reply_byte;
    logic        last;
    logic [9:0]  duty_a;
    logic [9:0]  duty_b;
    logic        gate_enable;
  } res_item_t;

  typedef res_item_t [REPLY_LEN-1:0] res_vec_t;

  typedef struct packed {
    logic [PUSH_CNT_W-1:0] count;
    res_vec_t              items;
  } res_push_t;

endpackage

`default_nettype wire

// ===== rtl/bdcl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// bdcl_res_fifo
// Result queue: takes up to three items in one cycle, hands out one a cycle while popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcl_res_fifo
  import bdcl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire res_push_t            push_i,
  input  wire logic                 pop_i,
  output logic [RES_CNT_W-1:0]      count_o,
  output res_item_t                 head_o
);

  res_item_t             mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0]  count_q, count_d;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < REPLY_LEN; k++) begin
      if (PUSH_CNT_W'(k) < push_i.count) begin
        mem_q[wr_ptr_q + RES_PTR_W'(k)] <= push_i.items[k];
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop_i);
    count_d  = count_q + RES_CNT_W'(push_i.count) - RES_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign count_o = count_q;
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/boost_duty_command_link_unit.sv =====
// ----------------------------------------------------------------------------
// boost_duty_command_link_unit
// Serial duty command link and control tick for a boost half-bridge stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   carries items of two kinds: a received serial byte or a timer tick
//          with fresh ADC samples. An item is taken when in_valid_i is high
//          and in_stall_o is low.
//   out_*  carries results: reply bytes (three per good frame, the third
//          marked last) and half-bridge duty updates on every control step.
//          A result leaves when out_valid_o is high and out_stall_i is low.
//   cfg_*  writes one control register per handshake; cfg_ready_o is always
//          high. Write only while the block is idle.
// Work: an item is worked while it sits in the input register and the
//   result queue has room for a full reply; its results are registered
//   into the queue and leave on out_* behind any results already queued.
// Throughput: one item per cycle while the result queue (four entries) has
//   room for a full reply; a good frame loads three reply bytes at once and
//   holds the input until two have drained, one per cycle when not stalled.
// Reset: clears the link state but for the first frame byte, sets the duties to 1023 and the gate off.
// A stalled receiver fills the queue; the input then stalls in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module boost_duty_command_link_unit
  import bdcl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output res_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Control registers.
  logic [7:0]  loop_divide_q, byte_timeout_q;
  logic [15:0] link_loss_limit_q;
  logic [8:0]  duty_min_q, duty_max_q;
  logic [9:0]  complement_base_q;

  // Input register.
  logic        in_valid_q, in_valid_d;
  in_item_t    in_q;

  // Link and control state.
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  sum_q, sum_d;
  logic        busy_q, busy_d;
  logic [7:0]  tcnt_q, tcnt_d;
  logic        link_ok_q, link_ok_d;
  logic [15:0] err_q, err_d;
  logic        on_q, on_d;
  logic [7:0]  div_q, div_d;
  logic [8:0]  duty_q, duty_d;
  logic [9:0]  bra_q, bra_d, brb_q, brb_d;
  logic [9:0]  vo_q, vo_d, vi_q, vi_d;

  // Work signals.
  logic                 proc;
  logic                 in_accept;
  logic [IDX_W:0]       idx_inc;
  logic [7:0]           div_inc, tcnt_inc, a_rb, b_rb;
  logic [15:0]          err_inc;
  logic                 fire, lk, on_t;
  logic [8:0]           duty_lo, duty_cl;
  logic signed [10:0]   diff;
  res_push_t            push;
  logic [RES_CNT_W-1:0] res_count;
  logic                 pop;

  // Work the held item only when the queue has room for a full reply.
  assign proc       = in_valid_q && (res_count <= RES_CNT_W'(RES_DEPTH - REPLY_LEN));
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_valid_d = in_accept ? 1'b1 : (proc ? 1'b0 : in_valid_q);

    idx_d   = idx_q;
    first_d = first_q;
    sum_d   = sum_q;
    busy_d  = busy_q;
    tcnt_d  = tcnt_q;
    link_ok_d = link_ok_q;
    err_d   = err_q;
    on_d    = on_q;
    div_d   = div_q;
    duty_d  = duty_q;
    bra_d   = bra_q;
    brb_d   = brb_q;
    vo_d    = vo_q;
    vi_d    = vi_q;

    idx_inc  = {1'b0, idx_q} + (IDX_W+1)'(1);
    div_inc  = div_q + 8'd1;
    fire     = div_inc > loop_divide_q;
    tcnt_inc = (tcnt_q != 8'hFF) ? tcnt_q + 8'd1 : tcnt_q;
    err_inc  = (err_q != 16'hFFFF) ? err_q + 16'd1 : err_q;
    a_rb     = 8'(vo_q >> ADC_SHIFT);
    b_rb     = 8'(vi_q >> ADC_SHIFT);
    lk       = link_ok_q;
    on_t     = on_q;
    duty_lo  = (duty_q < duty_min_q) ? duty_min_q : duty_q;
    duty_cl  = (duty_lo > duty_max_q) ? duty_max_q : duty_lo;
    diff     = $signed({1'b0, complement_base_q}) - $signed({2'b00, duty_cl});
    push     = '0;

    if (proc) begin
      case (in_q.func)
        FUNC_BYTE: begin
          busy_d = 1'b1;
          if (idx_q == '0) begin
            first_d = in_q.rx_byte;
          end
          if (idx_q < IDX_W'(FRAME_LEN - 1)) begin
            sum_d = sum_q + in_q.rx_byte;
          end
          if (idx_inc >= (IDX_W+1)'(FRAME_LEN)) begin
            // Frame complete: check the sum byte and restart assembly.
            idx_d     = '0;
            busy_d    = 1'b0;
            tcnt_d    = '0;
            sum_d     = '0;
            link_ok_d = (sum_q == in_q.rx_byte);
            if (sum_q == in_q.rx_byte) begin
              duty_d = {1'b0, first_q};
              on_d   = 1'b1;
              push.count = PUSH_CNT_W'(REPLY_LEN);
              push.items[0].kind       = KIND_REPLY;
              push.items[0].reply_byte = a_rb;
              push.items[1].kind       = KIND_REPLY;
              push.items[1].reply_byte = b_rb;
              push.items[2].kind       = KIND_REPLY;
              push.items[2].reply_byte = a_rb + b_rb;
              push.items[2].last       = 1'b1;
            end
          end else begin
            idx_d = idx_inc[IDX_W-1:0];
          end
        end
        FUNC_TICK: begin
          div_d = fire ? 8'd0 : div_inc;
          // Byte timeout drops a partial frame.
          if (busy_q) begin
            if (tcnt_inc > byte_timeout_q) begin
              idx_d  = '0;
              sum_d  = '0;
              busy_d = 1'b0;
              tcnt_d = '0;
              lk     = 1'b0;
            end else begin
              tcnt_d = tcnt_inc;
            end
          end
          link_ok_d = lk;
          // Link-loss watchdog.
          if (!lk) begin
            err_d = err_inc;
            if (err_inc > link_loss_limit_q) begin
              on_t = 1'b0;
            end
          end else begin
            err_d = '0;
          end
          on_d = on_t;
          if (fire) begin
            vo_d   = in_q.out_voltage;
            vi_d   = in_q.in_voltage;
            duty_d = duty_cl;
            if (on_t) begin
              if (diff < 11'sd1) begin
                bra_d = BRIDGE_MIN;
              end else if (diff > 11'sd1023) begin
                bra_d = BRIDGE_MAX;
              end else begin
                bra_d = diff[9:0];
              end
              brb_d = (duty_cl == '0) ? BRIDGE_MIN : {1'b0, duty_cl};
            end
            push.count = PUSH_CNT_W'(1);
            push.items[0].kind        = KIND_DUTY;
            push.items[0].duty_a      = bra_d;
            push.items[0].duty_b      = brb_d;
            push.items[0].gate_enable = on_t;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the item payload; load it only on accept.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    first_q <= first_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_divide_q     <= LOOP_DIVIDE_RST;
      byte_timeout_q    <= BYTE_TIMEOUT_RST;
      link_loss_limit_q <= LINK_LOSS_LIMIT_RST;
      duty_min_q        <= DUTY_MIN_RST;
      duty_max_q        <= DUTY_MAX_RST;
      complement_base_q <= COMPLEMENT_BASE_RST;
      in_valid_q <= 1'b0;
      idx_q      <= '0;
      sum_q      <= '0;
      busy_q     <= 1'b0;
      tcnt_q     <= '0;
      link_ok_q  <= 1'b0;
      err_q      <= '0;
      on_q       <= 1'b0;
      div_q      <= '0;
      duty_q     <= '0;
      bra_q      <= BRIDGE_MAX;
      brb_q      <= BRIDGE_MAX;
      vo_q       <= '0;
      vi_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LOOP_DIVIDE:     loop_divide_q     <= cfg_data_i[7:0];
          CFG_BYTE_TIMEOUT:    byte_timeout_q    <= cfg_data_i[7:0];
          CFG_LINK_LOSS_LIMIT: link_loss_limit_q <= cfg_data_i[15:0];
          CFG_DUTY_MIN:        duty_min_q        <= cfg_data_i[8:0];
          CFG_DUTY_MAX:        duty_max_q        <= cfg_data_i[8:0];
          CFG_COMPLEMENT_BASE: complement_base_q <= cfg_data_i[9:0];
          default: begin
          end
        endcase
      end
      in_valid_q <= in_valid_d;
      idx_q      <= idx_d;
      sum_q      <= sum_d;
      busy_q     <= busy_d;
      tcnt_q     <= tcnt_d;
      link_ok_q  <= link_ok_d;
      err_q      <= err_d;
      on_q       <= on_d;
      div_q      <= div_d;
      duty_q     <= duty_d;
      bra_q      <= bra_d;
      brb_q      <= brb_d;
      vo_q       <= vo_d;
      vi_q       <= vi_d;
    end
  end

  // Result queue parts the work stage from the receiver.
  assign pop = out_valid_o && !out_stall_i;

  bdcl_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .count_o (res_count),
    .head_o  (out_data_o)
  );

  assign out_valid_o = (res_count != '0);

endmodule

`default_nettype wire

// ===== rtl/bdcl_checker.sv =====
// ----------------------------------------------------------------------------
// bdcl_checker
// Port-level checks for the boost duty command link, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bdcl_checker
  import bdcl_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire res_item_t             out_data_o
);

  // Leaving reset: nothing to show and nothing held at the input.
  `BDCL_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> (!out_valid_o && !in_stall_o))

  // A stalled result stays and keeps its payload.
  `BDCL_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))

  // A reply is queued whole: after a non-final reply byte leaves, the next one is ready.
  `BDCL_ASSERT(a_reply_whole, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && out_data_o.kind == KIND_REPLY && !out_data_o.last)
    |=> (out_valid_o && out_data_o.kind == KIND_REPLY))

  // Duty updates never carry a zero duty.
  `BDCL_ASSERT(a_duty_nonzero, clk_i, rst_ni,
    (out_valid_o && out_data_o.kind == KIND_DUTY)
    |-> (out_data_o.duty_a != 10'd0 && out_data_o.duty_b != 10'd0))

endmodule

bind boost_duty_command_link_unit bdcl_checker u_bdcl_checker (.*);

`default_nettype wire
